// File: src/ttsm_pkg.sv
// Shared types, codes and helpers for the thermal task swap/migrate unit.
// No dependencies; every other file imports this package.
`default_nettype none

package ttsm_pkg;

  // Field widths
  localparam int TEMP_W   = 11;
  localparam int DELTA_W  = 32;
  localparam int THR_W    = 10;
  localparam int TICK_W   = 8;
  localparam int CORE_W   = 2;
  localparam int ACT_W    = 3;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  // Cores that the controller may choose from, and temperature fields carried
  localparam int CORE_COUNT  = 4;
  localparam int TEMP_FIELDS = 4;
  localparam int SCAN_CORES  = (CORE_COUNT < TEMP_FIELDS) ? CORE_COUNT : TEMP_FIELDS;

  // Register reset values, in 1/8 degree units where they are temperatures
  localparam logic [THR_W-1:0]  HIGH_THR_RESET = THR_W'(600);
  localparam logic [THR_W-1:0]  LOW_THR_RESET  = THR_W'(480);
  localparam logic [TICK_W-1:0] MIGRATE_RESET  = TICK_W'(10);
  localparam logic [TICK_W-1:0] TICK_MAX       = {TICK_W{1'b1}};

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_HIGH_THR = 2'd0,
    REG_LOW_THR  = 2'd1,
    REG_MIGRATE  = 2'd2
  } reg_idx_t;

  // Operation codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // Reported actions
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE        = 3'd0,
    ACT_TO_COLD     = 3'd1,
    ACT_TO_HOT      = 3'd2,
    ACT_MIGRATE     = 3'd3,
    ACT_WAITING     = 3'd4,
    ACT_FINISHED    = 3'd5,
    ACT_NOT_STARTED = 3'd6
  } action_t;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef temp_t [TEMP_FIELDS-1:0]  temp_vec_t;

  typedef struct packed {
    logic                      operation;
    logic signed [DELTA_W-1:0] busy_delta_a;
    logic signed [DELTA_W-1:0] busy_delta_b;
    temp_vec_t                 temps;
    logic                      hot_alive;
    logic                      cold_alive;
  } item_t;

  typedef struct packed {
    logic              hot_is_b;
    logic              hot_active;
    logic [CORE_W-1:0] core_sel;
    action_t           action;
  } result_t;

  typedef struct packed {
    logic [THR_W-1:0]  high_thr;
    logic [THR_W-1:0]  low_thr;
    logic [TICK_W-1:0] migrate_after;
  } cfg_t;

  // Lowest valid (non-negative) reading, lowest index on a tie, core 0 if none
  function automatic logic [CORE_W-1:0] coolest(input temp_vec_t t);
    logic [CORE_W-1:0] best;
    logic              found;
    temp_t             best_t;
    best   = '0;
    found  = 1'b0;
    best_t = '0;
    for (int i = 0; i < SCAN_CORES; i++) begin
      if (!t[i][TEMP_W-1] && (!found || t[i] < best_t)) begin
        found  = 1'b1;
        best_t = t[i];
        best   = CORE_W'(i);
      end
    end
    return best;
  endfunction

endpackage

`default_nettype wire

// File: src/ttsm_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on ttsm_pkg for field widths.
`default_nettype none

interface ttsm_in_if;
  import ttsm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [DELTA_W-1:0] busy_delta_a;
  logic signed [DELTA_W-1:0] busy_delta_b;
  logic signed [TEMP_W-1:0]  temp_core0;
  logic signed [TEMP_W-1:0]  temp_core1;
  logic signed [TEMP_W-1:0]  temp_core2;
  logic signed [TEMP_W-1:0]  temp_core3;
  logic                      hot_alive;
  logic                      cold_alive;

  modport source (
    output valid, operation, busy_delta_a, busy_delta_b,
           temp_core0, temp_core1, temp_core2, temp_core3, hot_alive, cold_alive,
    input  ready
  );
  modport sink (
    input  valid, operation, busy_delta_a, busy_delta_b,
           temp_core0, temp_core1, temp_core2, temp_core3, hot_alive, cold_alive,
    output ready
  );
endinterface

interface ttsm_out_if;
  import ttsm_pkg::*;
  logic              valid;
  logic              ready;
  logic              hot_is_b;
  logic              hot_active;
  logic [CORE_W-1:0] core_sel;
  logic [ACT_W-1:0]  action;

  modport source (
    output valid, hot_is_b, hot_active, core_sel, action,
    input  ready
  );
  modport sink (
    input  valid, hot_is_b, hot_active, core_sel, action,
    output ready
  );
endinterface

`default_nettype wire

// File: src/ttsm_cfg.sv
// APB-style register file: high/low thresholds and the migration tick limit.
// Depends on ttsm_pkg.
`default_nettype none

module ttsm_cfg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ttsm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ttsm_pkg::DATA_W-1:0] pwdata,
  output logic [ttsm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output ttsm_pkg::cfg_t              cfg
);
  import ttsm_pkg::*;

  logic [THR_W-1:0]  high_thr;
  logic [THR_W-1:0]  low_thr;
  logic [TICK_W-1:0] migrate_after;
  reg_idx_t          idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write on the access cycle; unmapped addresses are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      high_thr      <= HIGH_THR_RESET;
      low_thr       <= LOW_THR_RESET;
      migrate_after <= MIGRATE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_HIGH_THR: high_thr      <= pwdata[THR_W-1:0];
        REG_LOW_THR:  low_thr       <= pwdata[THR_W-1:0];
        REG_MIGRATE:  migrate_after <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_HIGH_THR: prdata = DATA_W'(high_thr);
      REG_LOW_THR:  prdata = DATA_W'(low_thr);
      REG_MIGRATE:  prdata = DATA_W'(migrate_after);
      default:      prdata = '0;
    endcase
  end

  assign cfg = '{high_thr: high_thr, low_thr: low_thr, migrate_after: migrate_after};

endmodule

`default_nettype wire

// File: src/ttsm_ctrl.sv
// Controller state and per-item decision: classify, swap, migrate, finish.
// Depends on ttsm_pkg.
`default_nettype none

module ttsm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  ttsm_pkg::item_t      item,
  input  ttsm_pkg::cfg_t       cfg,
  output ttsm_pkg::result_t    result
);
  import ttsm_pkg::*;

  logic              started, started_next;
  logic              done, done_next;
  logic              hot_b, hot_b_next;
  logic              hot_turn, hot_turn_next;
  logic [TICK_W-1:0] cold_ticks, cold_ticks_next;
  logic [CORE_W-1:0] core_now, core_now_next;
  action_t           action;

  logic [CORE_W-1:0] best_core;
  temp_t             cur_temp;
  logic              at_high;
  logic              below_low;
  logic [TICK_W-1:0] ticks_inc;

  assign best_core = coolest(item.temps);
  assign cur_temp  = item.temps[core_now];
  assign at_high   = cur_temp >= $signed({1'b0, cfg.high_thr});
  assign below_low = cur_temp <  $signed({1'b0, cfg.low_thr});
  assign ticks_inc = (cold_ticks == TICK_MAX) ? cold_ticks : cold_ticks + TICK_W'(1);

  // Next state and action for the item at the input register
  always_comb begin
    started_next    = started;
    done_next       = done;
    hot_b_next      = hot_b;
    hot_turn_next   = hot_turn;
    cold_ticks_next = cold_ticks;
    core_now_next   = core_now;
    action          = ACT_NONE;
    if (item.operation == OP_START) begin
      hot_b_next      = item.busy_delta_a < item.busy_delta_b;
      core_now_next   = best_core;
      hot_turn_next   = 1'b1;
      cold_ticks_next = '0;
      started_next    = 1'b1;
      done_next       = 1'b0;
    end else if (!started) begin
      action = ACT_NOT_STARTED;
    end else if (done) begin
      action = ACT_FINISHED;
    end else if (!item.hot_alive && !item.cold_alive) begin
      done_next = 1'b1;
      action    = ACT_FINISHED;
    end else if (hot_turn) begin
      // Hot task yields once the current core gets too warm and the cold task is alive
      if (at_high && item.cold_alive) begin
        hot_turn_next   = 1'b0;
        cold_ticks_next = '0;
        action          = ACT_TO_COLD;
      end
    end else begin
      cold_ticks_next = ticks_inc;
      if (below_low && item.hot_alive) begin
        hot_turn_next = 1'b1;
        action        = ACT_TO_HOT;
      end else if (ticks_inc > cfg.migrate_after && !below_low) begin
        // Move both tasks to the coolest core once the cold phase has lasted too long; wait if already there
        if (best_core != core_now) begin
          core_now_next   = best_core;
          cold_ticks_next = '0;
          action          = ACT_MIGRATE;
        end else begin
          action = ACT_WAITING;
        end
      end
    end
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      done       <= 1'b0;
      hot_b      <= 1'b0;
      hot_turn   <= 1'b0;
      cold_ticks <= '0;
      core_now   <= '0;
    end else if (fire) begin
      started    <= started_next;
      done       <= done_next;
      hot_b      <= hot_b_next;
      hot_turn   <= hot_turn_next;
      cold_ticks <= cold_ticks_next;
      core_now   <= core_now_next;
    end
  end

  assign result = '{hot_is_b: hot_b_next, hot_active: hot_turn_next,
                    core_sel: core_now_next, action: action};

endmodule

`default_nettype wire

// File: src/thermal_task_swap_migrate_unit.sv
// Thermal task swap/migrate unit: input register, decision logic, result register.
// Each result is registered in the result register after its item has left the input register.
// Throughput: one item per cycle while dout.ready holds; the state update lives in one combinational
// step between the input register and the result register.
// Reset (rst, synchronous): empties both registers, clears the controller state
// and loads register defaults (600, 480, 10). Depends on ttsm_pkg, ttsm_if.
`default_nettype none

module thermal_task_swap_migrate_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  ttsm_in_if.sink                     din,
  ttsm_out_if.source                  dout,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ttsm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ttsm_pkg::DATA_W-1:0] pwdata,
  output logic [ttsm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import ttsm_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    out_valid;
  result_t out_res;
  logic    advance;
  logic    fire;
  cfg_t    cfg;
  result_t next_res;

  assign advance   = !out_valid || dout.ready;
  assign fire      = s1_valid && advance;
  assign din.ready = !s1_valid || advance;

  // Input register: take an item whenever the stage is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      s1_item <= '{operation: din.operation,
                   busy_delta_a: din.busy_delta_a,
                   busy_delta_b: din.busy_delta_b,
                   temps: {din.temp_core3, din.temp_core2, din.temp_core1, din.temp_core0},
                   hot_alive: din.hot_alive,
                   cold_alive: din.cold_alive};
    end
  end

  ttsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ttsm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .cfg    (cfg),
    .result (next_res)
  );

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= next_res;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.hot_is_b   = out_res.hot_is_b;
  assign dout.hot_active = out_res.hot_active;
  assign dout.core_sel   = out_res.core_sel;
  assign dout.action     = out_res.action;

endmodule

`default_nettype wire

// File: src/ttsm_checker.sv
// Port-level checks on the result channel of the swap/migrate unit, and the bind.
// Depends on ttsm_pkg and thermal_task_swap_migrate_unit.
`default_nettype none

module ttsm_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic                   hot_is_b,
  input wire logic                   hot_active,
  input wire logic [ttsm_pkg::CORE_W-1:0] core_sel,
  input wire logic [ttsm_pkg::ACT_W-1:0]  action
);
  import ttsm_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds still
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(core_sel)
      && $stable(hot_active) && $stable(hot_is_b))
    else $error("stalled result changed");

  // A swap leaves the named task running
  a_swap_task: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_TO_COLD || action == ACT_TO_HOT)
      |-> hot_active == (action == ACT_TO_HOT))
    else $error("swap action disagrees with running task");

  // Before any start the state is still the reset state
  a_not_started: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_NOT_STARTED |-> !hot_is_b && !hot_active && core_sel == '0)
    else $error("not-started result shows changed state");

endmodule

bind thermal_task_swap_migrate_unit ttsm_checker u_ttsm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .hot_is_b   (dout.hot_is_b),
  .hot_active (dout.hot_active),
  .core_sel   (dout.core_sel),
  .action     (dout.action)
);

`default_nettype wire
